### rtl/core/preemptive_lifo_task_order_unit_assert.svh
// Assertion macros used by the checker file of the task order unit.
`ifndef PREEMPTIVE_LIFO_TASK_ORDER_UNIT_ASSERT_SVH
`define PREEMPTIVE_LIFO_TASK_ORDER_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define PLTO_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("task order unit check failed");

// Check that cons holds in the cycle after ante.
`define PLTO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("task order unit check failed");

`endif

### rtl/core/plto_pkg.sv
// Types and constants shared by the task order unit modules.
package plto_pkg;

    localparam int MAX_TASKS   = 64;
    localparam int IDX_W       = $clog2(MAX_TASKS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_W       = 11 + IDX_W;
    localparam logic [10:0] MIN_PER_HOUR = 11'd60;

    typedef struct packed {
        logic [7:0] task_id;
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [9:0] duration;
        logic       last_task;
    } task_in_t;

    typedef struct packed {
        logic [7:0] done_id;
        logic       last_done;
        logic       overflow;
    } task_out_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [10:0] start;
        logic [9:0]  len;
    } task_rec_t;

    typedef struct packed {
        logic [7:0] id;
        logic [9:0] rem;
    } stack_rec_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN_INIT, ST_SCAN_RD, ST_SCAN_CMP, ST_FETCH_RD, ST_FETCH_LD,
        ST_DECIDE, ST_POP_RD, ST_POP_CHK, ST_ADVANCE, ST_FINAL, ST_DRAIN_RD,
        ST_DRAIN_EM
    } state_t;

    typedef enum logic [3:0] {
        OP_IDLE, OP_LOAD, OP_SCAN_INIT, OP_SCAN_RD, OP_SCAN_CMP, OP_FETCH_RD,
        OP_FETCH_LD, OP_DECIDE, OP_POP_RD, OP_POP_CHK, OP_ADVANCE, OP_FINAL,
        OP_DRAIN_RD, OP_DRAIN_EM
    } dp_op_t;

    typedef struct packed {
        logic first;
        logic cnt_one;
        logic scan_end;
        logic adv_done;
        logic fin_eq;
        logic fin_gt;
        logic tf_eq;
        logic tf_gt;
        logic sp_zero;
        logic sp_one;
    } dp_status_t;

endpackage

### rtl/core/plto_ram.sv
// Generic single write port RAM with registered read.
module plto_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read on the clock
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/plto_ctrl.sv
// Controller state machine for the task order unit.
module plto_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   last_task,
    input  plto_pkg::dp_status_t   status,
    output plto_pkg::dp_op_t       op,
    output logic                   busy
);
    import plto_pkg::*;

    state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (start && last_task) state_next = ST_SCAN_INIT;
            ST_SCAN_INIT: state_next = ST_SCAN_RD;
            ST_SCAN_RD:   state_next = ST_SCAN_CMP;
            ST_SCAN_CMP:  state_next = status.scan_end ? ST_FETCH_RD : ST_SCAN_RD;
            ST_FETCH_RD:  state_next = ST_FETCH_LD;
            ST_FETCH_LD:
            begin
                if (status.first)
                begin
                    state_next = status.cnt_one ? ST_FINAL : ST_SCAN_INIT;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!status.fin_eq && !status.fin_gt && !status.sp_zero)
                begin
                    state_next = ST_POP_RD;
                end
                else
                begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_POP_RD:    state_next = ST_POP_CHK;
            ST_POP_CHK:
            begin
                if (status.tf_eq || status.tf_gt || status.sp_one)
                begin
                    state_next = ST_ADVANCE;
                end
                else
                begin
                    state_next = ST_POP_RD;
                end
            end
            ST_ADVANCE:   state_next = status.adv_done ? ST_FINAL : ST_SCAN_INIT;
            ST_FINAL:     state_next = status.sp_zero ? ST_IDLE : ST_DRAIN_RD;
            ST_DRAIN_RD:  state_next = ST_DRAIN_EM;
            ST_DRAIN_EM:  state_next = status.sp_one ? ST_IDLE : ST_DRAIN_RD;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:      op = start ? OP_LOAD : OP_IDLE;
            ST_SCAN_INIT: op = OP_SCAN_INIT;
            ST_SCAN_RD:   op = OP_SCAN_RD;
            ST_SCAN_CMP:  op = OP_SCAN_CMP;
            ST_FETCH_RD:  op = OP_FETCH_RD;
            ST_FETCH_LD:  op = OP_FETCH_LD;
            ST_DECIDE:    op = OP_DECIDE;
            ST_POP_RD:    op = OP_POP_RD;
            ST_POP_CHK:   op = OP_POP_CHK;
            ST_ADVANCE:   op = OP_ADVANCE;
            ST_FINAL:     op = OP_FINAL;
            ST_DRAIN_RD:  op = OP_DRAIN_RD;
            ST_DRAIN_EM:  op = OP_DRAIN_EM;
            default:      op = OP_IDLE;
        endcase
    end
endmodule

### rtl/core/plto_dp.sv
// Datapath of the task order unit: task store, scan, run simulation, stack.
module plto_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  plto_pkg::dp_op_t       op,
    input  plto_pkg::task_in_t     item,
    output plto_pkg::dp_status_t   status,
    output logic                   result_valid,
    output plto_pkg::task_out_t    result
);
    import plto_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] sp_reg, sp_next;
    logic             first_reg, first_next;
    logic             have_best_reg, have_best_next;
    logic [KEY_W-1:0] best_key_reg, best_key_next;
    logic [KEY_W-1:0] prev_key_reg, prev_key_next;
    task_rec_t        cur_reg, cur_next;
    task_rec_t        nxt_reg, nxt_next;
    logic [11:0]      t_reg, t_next;
    logic             vld_reg, vld_next;
    task_out_t        out_reg, out_next;

    logic             task_we;
    task_rec_t        task_wdata;
    logic [IDX_W-1:0] task_raddr;
    task_rec_t        task_rdata;
    logic             stk_we;
    logic [IDX_W-1:0] stk_waddr;
    stack_rec_t       stk_wdata;
    logic [IDX_W-1:0] stk_raddr;
    stack_rec_t       stk_rdata;

    logic [KEY_W-1:0] cand_key;
    logic             better;
    logic [11:0]      fin;
    logic [11:0]      ns;
    logic [11:0]      tf;
    logic [11:0]      push_rem;
    logic [11:0]      pop_rem;
    logic [CNT_W-1:0] sp_dec;
    logic [10:0]      start_min;

    plto_ram #(.WIDTH($bits(task_rec_t)), .DEPTH(MAX_TASKS)) u_task_ram (
        .clk   (clk),
        .we    (task_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (task_wdata),
        .raddr (task_raddr),
        .rdata (task_rdata)
    );

    plto_ram #(.WIDTH($bits(stack_rec_t)), .DEPTH(MAX_TASKS)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Compute keys, times and comparisons
    always_comb
    begin
        start_min  = 11'({6'd0, item.start_hour} * MIN_PER_HOUR) + {5'd0, item.start_minute};
        cand_key   = {task_rdata.start, k_reg[IDX_W-1:0]};
        better     = (first_reg || (cand_key > prev_key_reg))
                     && (!have_best_reg || (cand_key < best_key_reg));
        fin        = {1'b0, cur_reg.start} + {2'd0, cur_reg.len};
        ns         = {1'b0, nxt_reg.start};
        tf         = t_reg + {2'd0, stk_rdata.rem};
        push_rem   = {2'd0, cur_reg.len} - (ns - {1'b0, cur_reg.start});
        pop_rem    = {2'd0, stk_rdata.rem} - (ns - t_reg);
        sp_dec     = sp_reg - CNT_W'(1);
        task_raddr = (op == OP_FETCH_RD) ? best_key_reg[IDX_W-1:0] : k_reg[IDX_W-1:0];
        stk_raddr  = sp_dec[IDX_W-1:0];
        task_wdata = '{id: item.task_id, start: start_min, len: item.duration};

        status.first    = first_reg;
        status.cnt_one  = (cnt_reg == CNT_W'(1));
        status.scan_end = (k_reg == cnt_reg - CNT_W'(1));
        status.adv_done = (step_reg + CNT_W'(1) == cnt_reg - CNT_W'(1));
        status.fin_eq   = (fin == ns);
        status.fin_gt   = (fin > ns);
        status.tf_eq    = (tf == ns);
        status.tf_gt    = (tf > ns);
        status.sp_zero  = (sp_reg == '0);
        status.sp_one   = (sp_reg == CNT_W'(1));
    end

    // Execute the datapath command
    always_comb
    begin
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        k_next         = k_reg;
        step_next      = step_reg;
        sp_next        = sp_reg;
        first_next     = first_reg;
        have_best_next = have_best_reg;
        best_key_next  = best_key_reg;
        prev_key_next  = prev_key_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        t_next         = t_reg;
        vld_next       = 1'b0;
        out_next       = out_reg;
        task_we        = 1'b0;
        stk_we         = 1'b0;
        stk_waddr      = sp_reg[IDX_W-1:0];
        stk_wdata      = '{id: cur_reg.id, rem: push_rem[9:0]};
        unique case (op)
            OP_IDLE: ;
            OP_LOAD:
            begin
                step_next  = '0;
                sp_next    = '0;
                first_next = 1'b1;
                if (cnt_reg < CNT_W'(MAX_TASKS))
                begin
                    task_we  = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            OP_SCAN_INIT:
            begin
                k_next         = '0;
                have_best_next = 1'b0;
            end
            OP_SCAN_RD: ;
            OP_SCAN_CMP:
            begin
                if (better)
                begin
                    best_key_next  = cand_key;
                    have_best_next = 1'b1;
                end
                k_next = k_reg + CNT_W'(1);
            end
            OP_FETCH_RD: ;
            OP_FETCH_LD:
            begin
                prev_key_next = best_key_reg;
                first_next    = 1'b0;
                if (first_reg)
                begin
                    cur_next = task_rdata;
                end
                else
                begin
                    nxt_next = task_rdata;
                end
            end
            OP_DECIDE:
            begin
                if (status.fin_gt)
                begin
                    // Preempt the running task
                    if (sp_reg < CNT_W'(MAX_TASKS))
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    vld_next = 1'b1;
                    out_next = '{done_id: cur_reg.id, last_done: 1'b0, overflow: ovf_reg};
                    t_next   = fin;
                end
            end
            OP_POP_RD: ;
            OP_POP_CHK:
            begin
                if (status.tf_gt)
                begin
                    // Put the partly resumed task back with what is left
                    stk_we    = 1'b1;
                    stk_waddr = sp_dec[IDX_W-1:0];
                    stk_wdata = '{id: stk_rdata.id, rem: pop_rem[9:0]};
                end
                else
                begin
                    vld_next = 1'b1;
                    out_next = '{done_id: stk_rdata.id, last_done: 1'b0, overflow: ovf_reg};
                    sp_next  = sp_dec;
                    t_next   = tf;
                end
            end
            OP_ADVANCE:
            begin
                cur_next  = nxt_reg;
                step_next = step_reg + CNT_W'(1);
            end
            OP_FINAL:
            begin
                vld_next = 1'b1;
                out_next = '{done_id: cur_reg.id, last_done: status.sp_zero,
                             overflow: ovf_reg};
                if (status.sp_zero)
                begin
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end
            end
            OP_DRAIN_RD: ;
            OP_DRAIN_EM:
            begin
                vld_next = 1'b1;
                out_next = '{done_id: stk_rdata.id, last_done: status.sp_one,
                             overflow: ovf_reg};
                sp_next  = sp_dec;
                if (status.sp_one)
                begin
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Hold control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            step_reg      <= '0;
            sp_reg        <= '0;
            first_reg     <= 1'b0;
            have_best_reg <= 1'b0;
            vld_reg       <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            k_reg         <= k_next;
            step_reg      <= step_next;
            sp_reg        <= sp_next;
            first_reg     <= first_next;
            have_best_reg <= have_best_next;
            vld_reg       <= vld_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        best_key_reg <= best_key_next;
        prev_key_reg <= prev_key_next;
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        t_reg        <= t_next;
        out_reg      <= out_next;
    end

    assign result_valid = vld_reg;
    assign result       = out_reg;
endmodule

### rtl/core/preemptive_lifo_task_order_unit.sv
// Top level of the preemptive LIFO-resume task order unit.
// Usage: present a task on item and raise start; the transaction is taken at a
// rising edge where start is high and busy is low. Tasks load one per cycle
// into a 64-entry task memory; loads beyond 64 are dropped and flag overflow.
// The transaction with item.last_task set starts the run and raises busy.
// The run finds each next task by start time with a scan of the task memory,
// a read and a compare per loaded task, then simulates preemption with a
// stack memory. Completed task ids come out on result, each held for one cycle
// with result_valid high; result.last_done marks the final id of the run.
// The receiver cannot stall; results are never held back.
// busy falls in the cycle of the last result; the next set can load at once.
// Reset clears the count, stack depth, overflow flag and the state machine.
module preemptive_lifo_task_order_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  plto_pkg::task_in_t   item,
    output logic                 busy,
    output logic                 result_valid,
    output plto_pkg::task_out_t  result
);
    import plto_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    plto_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_task (item.last_task),
        .status    (status),
        .op        (op),
        .busy      (busy)
    );

    plto_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .item         (item),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );
endmodule

### rtl/core/plto_checker.sv
// Port level checks for the task order unit, bound to the top level.
`include "preemptive_lifo_task_order_unit_assert.svh"

module plto_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input plto_pkg::task_in_t   item,
    input logic                 busy,
    input logic                 result_valid,
    input plto_pkg::task_out_t  result
);
    import plto_pkg::*;

    // A load that is not the last keeps the unit free
    `PLTO_ASSERT_NEXT(a_load_stays_idle, start && !busy && !item.last_task, !busy)

    // The last task transaction starts a run
    `PLTO_ASSERT_NEXT(a_last_starts_run, start && !busy && item.last_task, busy)

    // No result follows an idle cycle
    `PLTO_ASSERT_NEXT(a_idle_no_result, !busy, !result_valid)

    // The final result of a run stands alone
    `PLTO_ASSERT_NEXT(a_last_done_ends, result_valid && result.last_done, !result_valid)
endmodule

bind preemptive_lifo_task_order_unit plto_checker u_plto_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
